FILE: src/spbr_pkg.sv
// Shared types and constants for the strobed parallel byte receiver.
// Used by spbr_core, the top level and the checker; no dependencies.
package spbr_pkg;

  // Fixed register widths
  localparam int HDR_W  = 4;
  localparam int DCNT_W = 16;
  localparam int TMO_W  = 24;
  localparam int BYTE_W = 8;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_HEADER_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_COUNT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 2'd2;

  localparam logic [HDR_W-1:0]  HEADER_COUNT_RST  = 4'd4;
  localparam logic [DCNT_W-1:0] DATA_COUNT_RST    = 16'd10000;
  localparam logic [TMO_W-1:0]  TIMEOUT_TICKS_RST = 24'd240000;

  // Result status codes
  localparam logic STATUS_DONE    = 1'b0;
  localparam logic STATUS_TIMEOUT = 1'b1;

  typedef enum logic [2:0] {
    PH_WAIT_LOW   = 3'd0,
    PH_WAIT_FIRST = 3'd1,
    PH_WAIT_FALL  = 3'd2,
    PH_WAIT_RISE  = 3'd3
  } phase_t;

  typedef struct packed {
    logic [HDR_W-1:0]  header_count;
    logic [DCNT_W-1:0] data_count;
    logic [TMO_W-1:0]  timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] sum_byte;
    logic              status;
  } res_t;

endpackage

FILE: src/spbr_core.sv
// Strobe edge tracker, byte counter, checksum and edge-wait timer.
// Uses spbr_pkg; advances one sample when step is high.
module spbr_core #(
  parameter int COUNT_BITS = 16,
  parameter int TIMER_BITS = 24
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step,
  input  logic                      strobe_req,
  input  logic [spbr_pkg::BYTE_W-1:0] bus_byte,
  input  spbr_pkg::cfg_t            cfg,
  output spbr_pkg::res_t            res
);

  localparam int CCMP_W = (COUNT_BITS > spbr_pkg::DCNT_W) ? COUNT_BITS : spbr_pkg::DCNT_W;
  localparam int TCMP_W = (TIMER_BITS > spbr_pkg::TMO_W) ? TIMER_BITS : spbr_pkg::TMO_W;

  spbr_pkg::phase_t               phase_r, phase_nxt;
  logic [COUNT_BITS-1:0]          bytes_r, bytes_nxt;
  logic                           payload_r, payload_nxt;
  logic [spbr_pkg::BYTE_W-1:0]    sum_r, sum_nxt;
  logic [TIMER_BITS-1:0]          timer_r, timer_nxt;
  logic [spbr_pkg::BYTE_W-1:0]    held_r, held_nxt;

  logic [COUNT_BITS-1:0]          bytes_inc;
  logic [TIMER_BITS-1:0]          timer_inc;
  logic                           timed_out;
  logic                           hdr_done;
  logic                           data_done;
  logic [spbr_pkg::BYTE_W-1:0]    sum_add;

  // Saturating counters and their compares
  assign bytes_inc = (bytes_r != {COUNT_BITS{1'b1}}) ? bytes_r + 1'b1 : bytes_r;
  assign timer_inc = (timer_r != {TIMER_BITS{1'b1}}) ? timer_r + 1'b1 : timer_r;
  assign timed_out = TCMP_W'(timer_inc) >= TCMP_W'(cfg.timeout_ticks);
  assign hdr_done  = CCMP_W'(bytes_inc) >= CCMP_W'(cfg.header_count);
  assign data_done = CCMP_W'(bytes_inc) >= CCMP_W'(cfg.data_count);
  assign sum_add   = sum_r + held_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= spbr_pkg::PH_WAIT_LOW;
      bytes_r   <= '0;
      payload_r <= 1'b0;
      sum_r     <= '0;
      timer_r   <= '0;
    end else begin
      phase_r   <= phase_nxt;
      bytes_r   <= bytes_nxt;
      payload_r <= payload_nxt;
      sum_r     <= sum_nxt;
      timer_r   <= timer_nxt;
    end
  end

  // Latched bus byte: always written at a rise before it is summed
  always_ff @(posedge clk) begin
    held_r <= held_nxt;
  end

  always_comb begin
    phase_nxt    = phase_r;
    bytes_nxt    = bytes_r;
    payload_nxt  = payload_r;
    sum_nxt      = sum_r;
    timer_nxt    = timer_r;
    held_nxt     = held_r;
    res.valid    = 1'b0;
    res.sum_byte = '0;
    res.status   = spbr_pkg::STATUS_DONE;
    if (step) begin
      case (phase_r)
        spbr_pkg::PH_WAIT_FIRST: begin
          if (strobe_req) begin
            held_nxt    = bus_byte;
            bytes_nxt   = '0;
            payload_nxt = (cfg.header_count == '0);
            sum_nxt     = '0;
            timer_nxt   = '0;
            phase_nxt   = spbr_pkg::PH_WAIT_FALL;
          end
        end
        spbr_pkg::PH_WAIT_FALL: begin
          if (strobe_req) begin
            timer_nxt = timer_inc;
            if (timed_out) begin
              res.valid  = 1'b1;
              res.status = spbr_pkg::STATUS_TIMEOUT;
              phase_nxt  = spbr_pkg::PH_WAIT_LOW;
            end
          end else begin
            timer_nxt = '0;
            if (!payload_r) begin
              if (hdr_done) begin
                payload_nxt = 1'b1;
                bytes_nxt   = '0;
              end else begin
                bytes_nxt = bytes_inc;
              end
              phase_nxt = spbr_pkg::PH_WAIT_RISE;
            end else begin
              sum_nxt   = sum_add;
              bytes_nxt = bytes_inc;
              if (data_done) begin
                res.valid    = 1'b1;
                res.sum_byte = sum_add;
                phase_nxt    = spbr_pkg::PH_WAIT_LOW;
              end else begin
                phase_nxt = spbr_pkg::PH_WAIT_RISE;
              end
            end
          end
        end
        spbr_pkg::PH_WAIT_RISE: begin
          if (strobe_req) begin
            held_nxt  = bus_byte;
            timer_nxt = '0;
            phase_nxt = spbr_pkg::PH_WAIT_FALL;
          end else begin
            timer_nxt = timer_inc;
            if (timed_out) begin
              res.valid  = 1'b1;
              res.status = spbr_pkg::STATUS_TIMEOUT;
              phase_nxt  = spbr_pkg::PH_WAIT_LOW;
            end
          end
        end
        default: begin
          // Idle and unused codes: wait for the strobe to go low
          phase_nxt = strobe_req ? spbr_pkg::PH_WAIT_LOW : spbr_pkg::PH_WAIT_FIRST;
        end
      endcase
    end
  end

endmodule

FILE: src/strobed_parallel_byte_receiver.sv
// Top level of the strobed parallel byte receiver: sample register,
// configuration registers and result register. Uses spbr_pkg and spbr_core.
//
//  channel | dir | ports                         | carries
//  --------+-----+-------------------------------+----------------------------------
//  in      | in  | in_tvalid/in_tready/in_tdata  | one pin sample: strobe, bus byte
//  out     | out | out_tvalid/out_tready/out_*   | sum byte (tdata), status (tuser)
//  cfg     | in  | cfg_valid/cfg_ready/cfg_*     | register write: index, data
//
// One sample is taken per cycle while in_tready is high; an accepted sample is held in the
// sample register until evaluated, and its result (if any) is registered to drive out_tvalid.
// The single result register is the only throttle: while a result is held
// by a low out_tready, the sample register fills and in_tready drops.
// Reset (rst_n low, synchronous) returns to idle and reloads register
// defaults: header_count 4, data_count 10000, timeout_ticks 240000.
// Configuration writes are taken every cycle and act on the next sample.
module strobed_parallel_byte_receiver #(
  parameter int COUNT_BITS = 16,
  parameter int TIMER_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [0] strobe_req, [8:1] bus_byte, [15:9] zero
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,
  // out_tdata: [7:0] sum_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,
  // out_tuser: [0] status
  output logic [0:0]  out_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [spbr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [spbr_pkg::CFG_DATA_W-1:0] cfg_data
);

  spbr_pkg::cfg_t              cfg_r;
  logic                        in_valid_r;
  logic                        in_strobe_r;
  logic [spbr_pkg::BYTE_W-1:0] in_bus_r;
  logic                        out_valid_r;
  logic [spbr_pkg::BYTE_W-1:0] out_sum_r;
  logic                        out_status_r;
  logic                        step;
  logic                        in_accept;
  spbr_pkg::res_t              core_res;

  // Evaluate the held sample whenever the result register can take a result
  assign step      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || step;
  assign in_accept = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Configuration registers; writes to unused indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_count  <= spbr_pkg::HEADER_COUNT_RST;
      cfg_r.data_count    <= spbr_pkg::DATA_COUNT_RST;
      cfg_r.timeout_ticks <= spbr_pkg::TIMEOUT_TICKS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        spbr_pkg::REG_HEADER_COUNT:  cfg_r.header_count  <= cfg_data[spbr_pkg::HDR_W-1:0];
        spbr_pkg::REG_DATA_COUNT:    cfg_r.data_count    <= cfg_data[spbr_pkg::DCNT_W-1:0];
        spbr_pkg::REG_TIMEOUT_TICKS: cfg_r.timeout_ticks <= cfg_data[spbr_pkg::TMO_W-1:0];
        default: ;
      endcase
    end
  end

  // Sample register: hold until evaluated, advance on accept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_accept) begin
      in_valid_r <= 1'b1;
    end else if (step) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_strobe_r <= in_tdata[0];
      in_bus_r    <= in_tdata[8:1];
    end
  end

  spbr_core #(
    .COUNT_BITS (COUNT_BITS),
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .strobe_req (in_strobe_r),
    .bus_byte   (in_bus_r),
    .cfg        (cfg_r),
    .res        (core_res)
  );

  // Result register: load a new result, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (core_res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (core_res.valid) begin
      out_sum_r    <= core_res.sum_byte;
      out_status_r <= core_res.status;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_sum_r;
  assign out_tuser[0] = out_status_r;

endmodule

FILE: src/spbr_checker.sv
// Port-level checks for the strobed parallel byte receiver.
// Uses spbr_pkg; bound to strobed_parallel_byte_receiver at the end of the file.
module spbr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic [0:0]  out_tuser,
  input logic        cfg_ready
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // A timeout reports a zero sum
  a_timeout_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[0] == spbr_pkg::STATUS_TIMEOUT) |-> out_tdata == 8'd0)
    else $error("timeout result with nonzero sum");

  // Reset empties the result register
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // With the output free, samples are never refused
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_tvalid || out_tready) |-> in_tready && cfg_ready)
    else $error("input stalled while output free");

endmodule

bind strobed_parallel_byte_receiver spbr_checker u_spbr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .cfg_ready  (cfg_ready)
);

FILE: dv/testbench.sv
// Self-checking testbench for strobed_parallel_byte_receiver: drives pin samples,
// register writes and result back-pressure, and checks every result.
// Depends on spbr_pkg and the receiver RTL only.
module testbench;

  localparam int DRAIN_CYCLES = 8;    // sample stage + result stage, with margin
  localparam int LONG_HOLD    = 300;  // receiver hold-off that fills the block
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 100;

  // Expected result: payload sum and completion status.
  typedef struct packed {
    logic [7:0] sum;
    logic       status;
  } sum_rec_t;

  // One row of the directed plan: either a register write or a pin sample,
  // optionally with a hand-written expected result.
  typedef struct packed {
    bit                              is_wr;
    logic [spbr_pkg::CFG_IDX_W-1:0]  idx;
    logic [spbr_pkg::CFG_DATA_W-1:0] val;
    logic                            strobe;
    logic [7:0]                      bus;
    bit                              typed;
    sum_rec_t                        res;
  } step_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [15:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic [0:0] out_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [spbr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [spbr_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  strobed_parallel_byte_receiver dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Receiver model: register copies and edge-tracking state.
  // ---------------------------------------------------------------------------
  logic [spbr_pkg::HDR_W-1:0]  skip_bytes;    // leading bytes dropped before summing
  logic [spbr_pkg::DCNT_W-1:0] sum_bytes;     // payload bytes added into the sum
  logic [spbr_pkg::TMO_W-1:0]  wait_limit;    // samples allowed per timed edge wait

  spbr_pkg::phase_t rx_phase;
  logic [15:0] byte_count;
  logic        past_header;
  logic [7:0]  acc_sum;
  logic [23:0] edge_timer;
  logic [7:0]  latched_byte;

  sum_rec_t due_sums[$];   // results predicted but not yet seen at the output
  int       items_taken = 0;
  int       mismatches = 0;
  bit       noisy = 1'b1;  // 0 = no gaps on either side
  int       hold_asks = 0;
  int       hold_served = 0;
  int       rdy_hold = 0;

  task automatic clear_model();
    skip_bytes   = spbr_pkg::HEADER_COUNT_RST;
    sum_bytes    = spbr_pkg::DATA_COUNT_RST;
    wait_limit   = spbr_pkg::TIMEOUT_TICKS_RST;
    rx_phase     = spbr_pkg::PH_WAIT_LOW;
    byte_count   = '0;
    past_header  = 1'b0;
    acc_sum      = '0;
    edge_timer   = '0;
    latched_byte = '0;
  endtask

  // Advance the edge timer (saturating) and report whether the wait ran out.
  function automatic bit timer_expired();
    if (edge_timer != '1) edge_timer = edge_timer + 1'b1;
    return edge_timer >= wait_limit;
  endfunction

  // Evaluate one pin sample; returns 1 when it produces a result.
  function automatic bit checksum_step(input logic strobe, input logic [7:0] bus,
                                       output sum_rec_t res);
    logic [15:0] next_cnt;
    res.sum    = '0;
    res.status = spbr_pkg::STATUS_DONE;
    case (rx_phase)
      spbr_pkg::PH_WAIT_FIRST: begin
        // First rise opens the transfer; the wait for it is not timed.
        if (strobe) begin
          latched_byte = bus;
          byte_count   = '0;
          past_header  = (skip_bytes == '0);
          acc_sum      = '0;
          edge_timer   = '0;
          rx_phase     = spbr_pkg::PH_WAIT_FALL;
        end
        return 1'b0;
      end
      spbr_pkg::PH_WAIT_FALL: begin
        if (strobe) begin
          if (timer_expired()) begin
            res.status = spbr_pkg::STATUS_TIMEOUT;
            rx_phase   = spbr_pkg::PH_WAIT_LOW;
            return 1'b1;
          end
          return 1'b0;
        end
        // Falling edge: the latched byte now counts.
        next_cnt   = (byte_count != '1) ? byte_count + 1'b1 : byte_count;
        edge_timer = '0;
        if (!past_header) begin
          if (next_cnt >= skip_bytes) begin
            past_header = 1'b1;
            byte_count  = '0;
          end else begin
            byte_count = next_cnt;
          end
          rx_phase = spbr_pkg::PH_WAIT_RISE;
          return 1'b0;
        end
        acc_sum    = acc_sum + latched_byte;
        byte_count = next_cnt;
        // A data count of zero ends after one byte, same as one.
        if (next_cnt >= sum_bytes) begin
          res.sum  = acc_sum;
          rx_phase = spbr_pkg::PH_WAIT_LOW;
          return 1'b1;
        end
        rx_phase = spbr_pkg::PH_WAIT_RISE;
        return 1'b0;
      end
      spbr_pkg::PH_WAIT_RISE: begin
        if (strobe) begin
          latched_byte = bus;
          edge_timer   = '0;
          rx_phase     = spbr_pkg::PH_WAIT_FALL;
          return 1'b0;
        end
        if (timer_expired()) begin
          res.status = spbr_pkg::STATUS_TIMEOUT;
          rx_phase   = spbr_pkg::PH_WAIT_LOW;
          return 1'b1;
        end
        return 1'b0;
      end
      default: begin
        // Idle: need strobe low before a rise can start a transfer.
        if (strobe) rx_phase = spbr_pkg::PH_WAIT_LOW;
        else rx_phase = spbr_pkg::PH_WAIT_FIRST;
        return 1'b0;
      end
    endcase
  endfunction

  // Gap length for either side: mostly none, some short, a few long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (!noisy || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure, long hold-off on request, and checking.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_side
    sum_rec_t want;
    int n;
    if (rst_n && out_tvalid && out_tready) begin
      if (due_sums.size() == 0) begin
        $display("%0t: unexpected result sum=%h status=%b", $time, out_tdata, out_tuser[0]);
        mismatches++;
      end else begin
        want = due_sums.pop_front();
        if (out_tdata !== want.sum) begin
          $display("%0t: sum_byte expected %h actual %h", $time, want.sum, out_tdata);
          mismatches++;
        end
        if (out_tuser[0] !== want.status) begin
          $display("%0t: status expected %b actual %b", $time, want.status, out_tuser[0]);
          mismatches++;
        end
      end
    end
    if (rdy_hold > 0) begin
      out_tready <= 1'b0;
      rdy_hold   <= rdy_hold - 1;
    end else if (hold_served != hold_asks) begin
      // Hold off long enough for the result register and sample stage to fill.
      hold_served <= hold_asks;
      out_tready  <= 1'b0;
      rdy_hold    <= LONG_HOLD - 1;
    end else begin
      n = idle_len();
      if (n > 0) begin
        out_tready <= 1'b0;
        rdy_hold   <= n - 1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side.
  // ---------------------------------------------------------------------------

  // Offer one pin sample, hold it until the request is taken, then predict.
  // With own_check set the caller supplies the expectation instead.
  task automatic send_sample(input logic strobe, input logic [7:0] bus, input bit own_check);
    int gap;
    sum_rec_t got;
    gap = idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, bus, strobe};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_taken++;
    if (checksum_step(strobe, bus, got) && !own_check) due_sums.push_back(got);
  endtask

  // Write one register; the model picks it up at the same handshake.
  task automatic write_reg(input logic [spbr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [spbr_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      spbr_pkg::REG_HEADER_COUNT:  skip_bytes = val[spbr_pkg::HDR_W-1:0];
      spbr_pkg::REG_DATA_COUNT:    sum_bytes  = val[spbr_pkg::DCNT_W-1:0];
      spbr_pkg::REG_TIMEOUT_TICKS: wait_limit = val[spbr_pkg::TMO_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stop offering, wait for every predicted result, then let the pipe empty.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (due_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic step_t smp(input logic strobe, input logic [7:0] bus);
    step_t s;
    s        = '0;
    s.strobe = strobe;
    s.bus    = bus;
    return s;
  endfunction

  function automatic step_t smp_res(input logic strobe, input logic [7:0] bus,
                                    input logic [7:0] sum, input logic status);
    step_t s;
    s            = smp(strobe, bus);
    s.typed      = 1'b1;
    s.res.sum    = sum;
    s.res.status = status;
    return s;
  endfunction

  function automatic step_t reg_wr(input logic [spbr_pkg::CFG_IDX_W-1:0] idx,
                                   input logic [spbr_pkg::CFG_DATA_W-1:0] val);
    step_t s;
    s       = '0;
    s.is_wr = 1'b1;
    s.idx   = idx;
    s.val   = val;
    return s;
  endfunction

  initial begin : stimulus
    step_t plan[$];
    int ph, k, nb, hi, lo, stretch, r, start;
    logic [spbr_pkg::HDR_W-1:0]  hv;
    logic [spbr_pkg::DCNT_W-1:0] dv;
    logic [spbr_pkg::TMO_W-1:0]  tv;

    clear_model();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. Start on reset defaults (header 4): a high strobe from
    // idle is ignored, then open a transfer and leave it waiting for a fall.
    plan.push_back(smp(1'b1, 8'h00));
    plan.push_back(smp(1'b0, 8'h00));
    plan.push_back(smp(1'b1, 8'hFF));
    // Zero timeout: the very next sample without a fall fails.
    plan.push_back(reg_wr(spbr_pkg::REG_HEADER_COUNT, 24'd0));
    plan.push_back(reg_wr(spbr_pkg::REG_DATA_COUNT, 24'd1));
    plan.push_back(reg_wr(spbr_pkg::REG_TIMEOUT_TICKS, 24'd0));
    plan.push_back(smp_res(1'b1, 8'h00, 8'h00, spbr_pkg::STATUS_TIMEOUT));
    // Zero header: the first byte is payload, one byte completes.
    plan.push_back(smp(1'b0, 8'h00));
    plan.push_back(smp(1'b1, 8'hFF));
    plan.push_back(smp_res(1'b0, 8'h00, 8'hFF, spbr_pkg::STATUS_DONE));
    // Zero data count acts like one.
    plan.push_back(reg_wr(spbr_pkg::REG_DATA_COUNT, 24'd0));
    plan.push_back(smp(1'b0, 8'h55));
    plan.push_back(smp(1'b1, 8'h80));
    plan.push_back(smp_res(1'b0, 8'h7F, 8'h80, spbr_pkg::STATUS_DONE));
    // One header byte, two payload bytes wrapping to zero, widest timeout.
    plan.push_back(reg_wr(spbr_pkg::REG_HEADER_COUNT, 24'd1));
    plan.push_back(reg_wr(spbr_pkg::REG_DATA_COUNT, 24'd2));
    plan.push_back(reg_wr(spbr_pkg::REG_TIMEOUT_TICKS, 24'hFFFFFF));
    plan.push_back(smp(1'b0, 8'hAA));
    plan.push_back(smp(1'b1, 8'h12));
    plan.push_back(smp(1'b0, 8'h00));
    plan.push_back(smp(1'b1, 8'hFF));
    plan.push_back(smp(1'b0, 8'h00));
    plan.push_back(smp(1'b1, 8'h01));
    plan.push_back(smp_res(1'b0, 8'h00, 8'h00, spbr_pkg::STATUS_DONE));

    foreach (plan[i]) begin
      if (plan[i].is_wr) begin
        settle();
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        send_sample(plan[i].strobe, plan[i].bus, plan[i].typed);
        if (plan[i].typed) due_sums.push_back(plan[i].res);
      end
    end

    // Random part: each phase sets all registers while the block is drained,
    // then streams mostly well-formed transfers with random content.
    for (ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0: begin hv = 4'd15; dv = 16'd3;     tv = 24'd1;       end
        1: begin hv = 4'd0;  dv = 16'hFFFF;  tv = 24'd5;       end
        2: begin hv = 4'd0;  dv = 16'd1;     tv = 24'hFFFFFF;  end
        default: begin
          r = $urandom_range(0, 3);
          hv = (r == 0) ? 4'd0 : (r == 1) ? 4'd15 : 4'($urandom_range(0, 15));
          r = $urandom_range(0, 99);
          if (r < 60) dv = 16'($urandom_range(1, 6));
          else if (r < 70) dv = 16'd0;
          else if (r < 78) dv = 16'hFFFF;
          else dv = 16'($urandom_range(7, 20));
          r = $urandom_range(0, 99);
          if (r < 35) tv = 24'($urandom_range(0, 6));
          else if (r < 55) tv = 24'hFFFFFF;
          else if (r < 75) tv = 24'($urandom_range(7, 40));
          else tv = spbr_pkg::TIMEOUT_TICKS_RST;
        end
      endcase
      write_reg(spbr_pkg::REG_HEADER_COUNT, spbr_pkg::CFG_DATA_W'(hv));
      write_reg(spbr_pkg::REG_DATA_COUNT, spbr_pkg::CFG_DATA_W'(dv));
      write_reg(spbr_pkg::REG_TIMEOUT_TICKS, spbr_pkg::CFG_DATA_W'(tv));
      noisy = (ph % 4 != 3);
      // Single-byte transfers while the receiver holds off: results pile up
      // and the block must stall its input.
      if (ph == 2) hold_asks++;

      start = items_taken;
      while (items_taken - start < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 15) begin
          // Noise: random strobe levels.
          repeat ($urandom_range(1, 6))
            send_sample(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0);
        end else begin
          nb = int'(skip_bytes) + ((sum_bytes == '0) ? 1 : int'(sum_bytes));
          if (nb > 24) nb = 24;
          // Cut some transfers short so they time out or run into the next.
          if (r < 25) nb = $urandom_range(1, nb);
          stretch = (wait_limit < 40) ? int'(wait_limit) + $urandom_range(0, 1) : 40;
          repeat ($urandom_range(1, 3)) send_sample(1'b0, 8'($urandom_range(0, 255)), 1'b0);
          for (k = 0; k < nb; k++) begin
            send_sample(1'b1, 8'($urandom_range(0, 255)), 1'b0);
            hi = ($urandom_range(0, 19) == 0) ? stretch : $urandom_range(0, 2);
            repeat (hi) send_sample(1'b1, 8'($urandom_range(0, 255)), 1'b0);
            lo = ($urandom_range(0, 19) == 0) ? stretch : $urandom_range(1, 3);
            repeat (lo) send_sample(1'b0, 8'($urandom_range(0, 255)), 1'b0);
          end
        end
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin : watchdog
    #16000000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule
